>>> src/csim_pkg.sv
// shared types, constants and arithmetic helpers for the cosine similarity unit
package csim_pkg;

  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int ACC_W       = 44;
  localparam int ROOT_W      = ACC_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int MIN_DEN_W   = 10;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int DIV_STEPS   = ELEM_W;
  localparam int STEP_CNT_W  = $clog2(SQRT_STEPS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MIN_DEN_W-1:0] MIN_DEN_RESET = MIN_DEN_W'(10);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [ELEM_W-1:0] SIM_POS_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SIM_NEG_MAX = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic signed [ACC_W-1:0] a_sq;
    logic signed [ACC_W-1:0] b_sq;
  } sums_t;

  typedef struct packed {
    logic [ACC_W-1:0]  x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(acc) + (ACC_W+1)'(prod);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  // one digit of the restoring square root, two radicand bits per step
  function automatic sqrt_t sqrt_step(input sqrt_t cur);
    sqrt_t            nxt;
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] trial;
    t     = {cur.rem[REM_W-3:0], cur.x[ACC_W-1:ACC_W-2]};
    trial = REM_W'({cur.root, 2'b01});
    nxt.x = {cur.x[ACC_W-3:0], 2'b00};
    if (t >= trial) begin
      nxt.rem  = t - trial;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = t;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

>>> src/cosine_similarity_unit.sv
// top level of the cosine similarity unit
// The unit takes one element pair per clock while its queue has room, with push/full on the
// input side and empty/pop on the result side. Accumulation of the dot product and both sums
// of squares runs in the front end at one beat per cycle. Each beat marked last hands its
// three sums to a two-deep queue. The back end takes each vector pair through a load from
// the queue, 22 shared square-root steps for the two norms, one multiply, one threshold
// check, 16 restoring divide steps and a write of the result register (the divide is
// skipped when the result is forced to zero or |dot| is at least twice the norm product).
// Long vectors stream at one element per cycle while results are popped, short ones at the
// back end's pace. The threshold register is written via cfg_we/cfg_wdata and resets to 10.
module cosine_similarity_unit #(
  parameter int QUEUE_DEPTH = csim_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [csim_pkg::MIN_DEN_W-1:0]       cfg_wdata,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [csim_pkg::ELEM_W-1:0]   in_a_elem,
  input  logic signed [csim_pkg::ELEM_W-1:0]   in_b_elem,
  input  logic                                 in_last_elem,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [csim_pkg::ELEM_W-1:0]   out_similarity,
  output logic                                 out_zero_norm
);

  logic [csim_pkg::MIN_DEN_W-1:0] min_den_r;
  logic                           accept;
  logic                           q_push;
  csim_pkg::sums_t                q_data;
  csim_pkg::sums_t                q_head;
  logic                           q_pop;
  logic                           q_empty;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_den_r <= csim_pkg::MIN_DEN_RESET;
    end else if (cfg_we) begin
      min_den_r <= cfg_wdata;
    end
  end

  csim_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .a_elem    (in_a_elem),
    .b_elem    (in_b_elem),
    .last_elem (in_last_elem),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  csim_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (full),
    .empty     (q_empty)
  );

  csim_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .min_den        (min_den_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_pop        (pop),
    .out_empty      (empty),
    .out_similarity (out_similarity),
    .out_zero_norm  (out_zero_norm)
  );

endmodule

>>> src/csim_front.sv
// front end: per-beat saturating accumulation of dot product and squares
module csim_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic signed [csim_pkg::ELEM_W-1:0]   a_elem,
  input  logic signed [csim_pkg::ELEM_W-1:0]   b_elem,
  input  logic                                 last_elem,
  output logic                                 q_push,
  output csim_pkg::sums_t                      q_data
);

  csim_pkg::sums_t acc_r;
  csim_pkg::sums_t acc_nxt;
  csim_pkg::sums_t upd;

  logic signed [csim_pkg::PROD_W-1:0] p_ab;
  logic signed [csim_pkg::PROD_W-1:0] p_aa;
  logic signed [csim_pkg::PROD_W-1:0] p_bb;

  always_comb begin
    p_ab     = a_elem * b_elem;
    p_aa     = a_elem * a_elem;
    p_bb     = b_elem * b_elem;
    upd.dot  = csim_pkg::sat_add(acc_r.dot, p_ab);
    upd.a_sq = csim_pkg::sat_add(acc_r.a_sq, p_aa);
    upd.b_sq = csim_pkg::sat_add(acc_r.b_sq, p_bb);
    acc_nxt  = acc_r;
    if (accept) begin
      acc_nxt = last_elem ? '0 : upd;
    end
  end

  assign q_push = accept && last_elem;
  assign q_data = upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

>>> src/csim_queue.sv
// short queue of finished sums between front and back end
module csim_queue #(
  parameter int DEPTH = csim_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  csim_pkg::sums_t push_data,
  input  logic            pop,
  output csim_pkg::sums_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  csim_pkg::sums_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");
`endif

endmodule

>>> src/csim_back.sv
// back end: square roots, norm product, threshold test, division and result register
module csim_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [csim_pkg::MIN_DEN_W-1:0]       min_den,
  input  logic                                 q_empty,
  input  csim_pkg::sums_t                      q_head,
  output logic                                 q_pop,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [csim_pkg::ELEM_W-1:0]   out_similarity,
  output logic                                 out_zero_norm
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SQRT  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [csim_pkg::STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  csim_pkg::sqrt_t                 sq_a_r, sq_a_nxt;
  csim_pkg::sqrt_t                 sq_b_r, sq_b_nxt;
  logic [csim_pkg::ACC_W-1:0]      mag_r, mag_nxt;
  logic                            neg_r, neg_nxt;
  logic [csim_pkg::ACC_W-1:0]      den_r, den_nxt;
  logic [csim_pkg::ACC_W-1:0]      rem_r, rem_nxt;
  logic                            nbit_r, nbit_nxt;
  logic [csim_pkg::ELEM_W-1:0]     quo_r, quo_nxt;
  logic                            zero_r, zero_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [csim_pkg::ELEM_W-1:0]     sim_r, sim_nxt;
  logic                            zn_r, zn_nxt;

  logic [csim_pkg::ACC_W:0]        div_t;
  logic                            div_ge;
  logic [csim_pkg::ELEM_W-1:0]     sim_calc;
  logic                            out_free;

  assign out_free  = !out_valid_r || out_pop;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign div_t     = {rem_r, nbit_r};
  assign div_ge    = div_t >= {1'b0, den_r};

  always_comb begin
    if (zero_r) begin
      sim_calc = '0;
    end else if (!neg_r) begin
      sim_calc = (quo_r > csim_pkg::SIM_POS_MAX) ? csim_pkg::SIM_POS_MAX : quo_r;
    end else begin
      sim_calc = (quo_r > csim_pkg::SIM_NEG_MAX) ? csim_pkg::SIM_NEG_MAX
                                                 : (~quo_r + 1'b1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sq_a_nxt      = sq_a_r;
    sq_b_nxt      = sq_b_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    nbit_nxt      = nbit_r;
    quo_nxt       = quo_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_pop;
    sim_nxt       = sim_r;
    zn_nxt        = zn_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          sq_a_nxt.x    = q_head.a_sq;
          sq_a_nxt.rem  = '0;
          sq_a_nxt.root = '0;
          sq_b_nxt.x    = q_head.b_sq;
          sq_b_nxt.rem  = '0;
          sq_b_nxt.root = '0;
          neg_nxt       = q_head.dot[csim_pkg::ACC_W-1];
          mag_nxt       = q_head.dot[csim_pkg::ACC_W-1] ? csim_pkg::ACC_W'(-q_head.dot)
                                                       : q_head.dot;
          cnt_nxt       = '0;
          state_nxt     = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sq_a_nxt = csim_pkg::sqrt_step(sq_a_r);
        sq_b_nxt = csim_pkg::sqrt_step(sq_b_r);
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == csim_pkg::STEP_CNT_W'(csim_pkg::SQRT_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        den_nxt   = sq_a_r.root * sq_b_r.root;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        zero_nxt = 1'b0;
        quo_nxt  = '0;
        if (den_r <= csim_pkg::ACC_W'(min_den)) begin
          zero_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if ({1'b0, mag_r} >= {den_r, 1'b0}) begin
          quo_nxt   = '1;
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = {1'b0, mag_r[csim_pkg::ACC_W-1:1]};
          nbit_nxt  = mag_r[0];
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? csim_pkg::ACC_W'(div_t - {1'b0, den_r})
                          : div_t[csim_pkg::ACC_W-1:0];
        quo_nxt  = {quo_r[csim_pkg::ELEM_W-2:0], div_ge};
        nbit_nxt = 1'b0;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == csim_pkg::STEP_CNT_W'(csim_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          sim_nxt       = sim_calc;
          zn_nxt        = zero_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_a_r <= sq_a_nxt;
    sq_b_r <= sq_b_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    nbit_r <= nbit_nxt;
    quo_r  <= quo_nxt;
    zero_r <= zero_nxt;
    sim_r  <= sim_nxt;
    zn_r   <= zn_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_similarity = sim_r;
  assign out_zero_norm  = zn_r;

`ifndef SYNTHESIS
  a_zero_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && zn_r) |-> (sim_r == '0))
    else $error("zero_norm beat with nonzero similarity");
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("division remainder not below denominator");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < csim_pkg::STEP_CNT_W'(csim_pkg::DIV_STEPS)))
    else $error("division step count overrun");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_SQRT))
    else $error("queue pop did not start square root");
`endif

endmodule

>>> bench/cosine_similarity_unit_checker.sv
// checker for the cosine similarity unit: predicts each result beat and compares it
`timescale 1ns / 1ps
module cosine_similarity_unit_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [csim_pkg::MIN_DEN_W-1:0]       cfg_wdata,
  input  logic                                 push,
  input  logic                                 full,
  input  logic signed [csim_pkg::ELEM_W-1:0]   in_a_elem,
  input  logic signed [csim_pkg::ELEM_W-1:0]   in_b_elem,
  input  logic                                 in_last_elem,
  input  logic                                 empty,
  input  logic                                 pop,
  input  logic signed [csim_pkg::ELEM_W-1:0]   out_similarity,
  input  logic                                 out_zero_norm,
  output int                                   mismatches,
  output int                                   outstanding
);

  typedef struct packed {
    logic signed [csim_pkg::ELEM_W-1:0] similarity;
    logic                               zero_norm;
  } cos_result_t;

  logic signed [csim_pkg::ACC_W-1:0] dot_acc;
  logic signed [csim_pkg::ACC_W-1:0] a_sq_acc;
  logic signed [csim_pkg::ACC_W-1:0] b_sq_acc;
  logic [csim_pkg::MIN_DEN_W-1:0]    min_den;
  cos_result_t                       expected_sims[$];
  int                                mismatch_total = 0;
  int                                result_num = 0;

  assign mismatches = mismatch_total;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  function automatic logic signed [csim_pkg::ACC_W-1:0] clamp_add(
    input logic signed [csim_pkg::ACC_W-1:0] acc,
    input longint                            prod
  );
    longint total;
    total = longint'(acc) + prod;
    if (total > longint'(csim_pkg::ACC_MAX)) return csim_pkg::ACC_MAX;
    if (total < longint'(csim_pkg::ACC_MIN)) return csim_pkg::ACC_MIN;
    return csim_pkg::ACC_W'(total);
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int i = csim_pkg::ROOT_W - 1; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= x) root = cand;
    end
    return root;
  endfunction

  function automatic cos_result_t cosine_of_sums();
    longint unsigned norm_a;
    longint unsigned norm_b;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned quot;
    longint          dot;
    logic            neg;
    cos_result_t     r;
    norm_a = floor_root(64'(a_sq_acc));
    norm_b = floor_root(64'(b_sq_acc));
    den    = norm_a * norm_b;
    if (den <= 64'(min_den)) begin
      r.similarity = '0;
      r.zero_norm  = 1'b1;
    end else begin
      dot  = longint'(dot_acc);
      neg  = dot < 0;
      mag  = neg ? -dot : dot;
      quot = (mag << 15) / den;
      if (neg) begin
        r.similarity = (quot > 64'd32768) ? csim_pkg::SIM_NEG_MAX : csim_pkg::ELEM_W'(-quot);
      end else begin
        r.similarity = (quot > 64'd32767) ? csim_pkg::SIM_POS_MAX : csim_pkg::ELEM_W'(quot);
      end
      r.zero_norm = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    cos_result_t want;
    if (!rst_n) begin
      dot_acc  = '0;
      a_sq_acc = '0;
      b_sq_acc = '0;
      min_den  = csim_pkg::MIN_DEN_RESET;
      expected_sims.delete();
    end else begin
      if (cfg_we) min_den = cfg_wdata;
      if (push && !full) begin
        dot_acc  = clamp_add(dot_acc, longint'(in_a_elem) * longint'(in_b_elem));
        a_sq_acc = clamp_add(a_sq_acc, longint'(in_a_elem) * longint'(in_a_elem));
        b_sq_acc = clamp_add(b_sq_acc, longint'(in_b_elem) * longint'(in_b_elem));
        if (in_last_elem) begin
          expected_sims.push_back(cosine_of_sums());
          dot_acc  = '0;
          a_sq_acc = '0;
          b_sq_acc = '0;
        end
      end
      if (pop && !empty) begin
        result_num++;
        if (expected_sims.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", result_num));
        end else begin
          want = expected_sims.pop_front();
          if (out_similarity !== want.similarity) begin
            report_mismatch($sformatf("result %0d similarity got %0d expected %0d",
                                      result_num, out_similarity, want.similarity));
          end
          if (out_zero_norm !== want.zero_norm) begin
            report_mismatch($sformatf("result %0d zero_norm got %0b expected %0b",
                                      result_num, out_zero_norm, want.zero_norm));
          end
        end
      end
    end
    outstanding <= expected_sims.size();
  end

endmodule

>>> bench/cosine_similarity_unit_tb.sv
// top of the cosine similarity testbench: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps
module cosine_similarity_unit_tb;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS  = 240;
  localparam int PHASE_COUNT  = 6;
  localparam int SAT_LEN      = 48;

  typedef enum int {STYLE_WIDE, STYLE_SMALL, STYLE_MATCHED, STYLE_ONE_ZERO, STYLE_CORNER}
    vec_style_t;

  logic                                 clk;
  logic                                 rst_n = 1'b0;
  logic                                 cfg_we = 1'b0;
  logic [csim_pkg::MIN_DEN_W-1:0]       cfg_wdata = '0;
  logic                                 push = 1'b0;
  logic                                 full;
  logic signed [csim_pkg::ELEM_W-1:0]   in_a_elem = '0;
  logic signed [csim_pkg::ELEM_W-1:0]   in_b_elem = '0;
  logic                                 in_last_elem = 1'b0;
  logic                                 empty;
  logic                                 pop = 1'b0;
  logic signed [csim_pkg::ELEM_W-1:0]   out_similarity;
  logic                                 out_zero_norm;
  int                                   mismatches;
  int                                   outstanding;

  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int stall_max = 1;
  int stall_left = 0;
  int idle_cycles = 0;
  int items_sent = 0;

  logic signed [csim_pkg::ELEM_W-1:0] corners [5] =
    '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  cosine_similarity_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .in_a_elem      (in_a_elem),
    .in_b_elem      (in_b_elem),
    .in_last_elem   (in_last_elem),
    .empty          (empty),
    .pop            (pop),
    .out_similarity (out_similarity),
    .out_zero_norm  (out_zero_norm)
  );

  cosine_similarity_unit_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .in_a_elem      (in_a_elem),
    .in_b_elem      (in_b_elem),
    .in_last_elem   (in_last_elem),
    .empty          (empty),
    .pop            (pop),
    .out_similarity (out_similarity),
    .out_zero_norm  (out_zero_norm),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // result side stalls in runs of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(stall_max);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pair(input logic signed [csim_pkg::ELEM_W-1:0] a,
                           input logic signed [csim_pkg::ELEM_W-1:0] b,
                           input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(32, 1);
    end
    push <= 1'b1;
    in_a_elem <= a;
    in_b_elem <= b;
    in_last_elem <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_vector(input int len, input vec_style_t style);
    logic signed [csim_pkg::ELEM_W-1:0] a;
    logic signed [csim_pkg::ELEM_W-1:0] b;
    logic                               zero_a;
    zero_a = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      a = csim_pkg::ELEM_W'($urandom);
      b = csim_pkg::ELEM_W'($urandom);
      case (style)
        STYLE_SMALL: begin
          a = csim_pkg::ELEM_W'($urandom_range(80) - 40);
          b = csim_pkg::ELEM_W'($urandom_range(80) - 40);
        end
        STYLE_MATCHED: begin
          case ($urandom_range(2))
            0: b = a;
            1: b = -a;
            default: b = csim_pkg::ELEM_W'(a + ($urandom_range(200) - 100));
          endcase
        end
        STYLE_ONE_ZERO: begin
          if (zero_a) a = '0;
          else b = '0;
        end
        STYLE_CORNER: begin
          a = corners[3'($urandom_range(4))];
          b = corners[3'($urandom_range(4))];
        end
        default: ;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  task automatic write_threshold(input logic [csim_pkg::MIN_DEN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // lets every expected beat come out and the back end go quiet
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int                             len;
    int                             pick;
    int                             target;
    vec_style_t                     style;
    logic [csim_pkg::MIN_DEN_W-1:0] thr;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-scale single pairs, a ratio of plus one saturates
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    // zero and tiny norms around the reset threshold
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sh7fff, 1'b1);
    send_pair(16'sd3, 16'sd3, 1'b1);
    send_pair(16'sd5, 16'sd2, 1'b1);
    send_pair(16'sd11, 16'sd1, 1'b1);
    // short vectors with normal results, the last with norms at or below the threshold
    send_pair(16'sd1000, -16'sd2000, 1'b0);
    send_pair(-16'sd5, 16'sd7, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sd12345, -16'sd23456, 1'b0);
    send_pair(16'sh8000, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sh8000, 1'b1);
    send_pair(-16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b1);
    // long full-scale vectors, both signs of the dot product
    for (int i = 0; i < SAT_LEN; i++) send_pair(16'sh8000, 16'sh7fff, i == SAT_LEN - 1);
    for (int i = 0; i < SAT_LEN; i++) send_pair(16'sh8000, 16'sh8000, i == SAT_LEN - 1);
    settle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: thr = '0;
        1: thr = '1;
        3: thr = csim_pkg::MIN_DEN_RESET;
        default: thr = csim_pkg::MIN_DEN_W'($urandom_range(1023));
      endcase
      write_threshold(thr);
      case (p % 3)
        0: begin
          gap_max = 0;
          stall_pct <= 0;
          stall_max <= 1;
        end
        1: begin
          gap_max = 4;
          stall_pct <= 20;
          stall_max <= 6;
        end
        default: begin
          gap_max = 24;
          stall_pct <= 5;
          stall_max <= 80;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(9);
        if (pick < 3) style = STYLE_WIDE;
        else if (pick < 5) style = STYLE_SMALL;
        else if (pick < 7) style = STYLE_MATCHED;
        else if (pick < 8) style = STYLE_ONE_ZERO;
        else style = STYLE_CORNER;
        pick = $urandom_range(9);
        if (style == STYLE_SMALL) len = $urandom_range(4, 1);
        else if (pick < 6) len = $urandom_range(8, 1);
        else if (pick < 9) len = $urandom_range(64, 9);
        else len = $urandom_range(200, 65);
        send_vector(len, style);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
